// File: rtl/core/dpb_pkg.sv
// Shared types, constants and helpers for the depth pixel back-projection block.
`default_nettype none
package dpb_pkg;

    localparam int DEPTH_W = 16;
    localparam int LABEL_W = 16;
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 13;
    localparam int CTR_W   = 16;
    localparam int INV_W   = 25;
    localparam int MAG_W   = 16;
    localparam int MZ_W    = MAG_W + DEPTH_W;
    localparam int PROD_W  = MZ_W + INV_W;
    localparam int FRAC_W  = 24;

    localparam int S_TDATA_W = DEPTH_W + LABEL_W;
    localparam int M_TDATA_W = 2 * COORD_W + DEPTH_W;
    localparam int M_TUSER_W = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register index codes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CTR_W-1:0]  RST_CENTER_X     = 16'd5120;
    localparam logic [CTR_W-1:0]  RST_CENTER_Y     = 16'd3840;
    localparam logic [INV_W-1:0]  RST_INV_FOCAL    = 25'd27962;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [CTR_W-1:0]  center_x_q4;
        logic [CTR_W-1:0]  center_y_q4;
        logic [INV_W-1:0]  inv_focal_x_q24;
        logic [INV_W-1:0]  inv_focal_y_q24;
    } dpb_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } dpb_state_t;

    typedef struct packed {
        logic load_in;
        logic do_mag;
        logic do_mul1;
        logic do_mul2;
        logic do_out;
    } dpb_cmd_t;

    typedef struct packed {
        logic out_free;
    } dpb_status_t;

    // Q28 magnitude to Q4 with floor of the signed value, saturated to int32.
    // Returns {saturated, value}.
    function automatic logic [COORD_W:0] round_sat(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
        logic [PROD_W:0]          up;
        logic [PROD_W-FRAC_W:0]   q;
        logic [COORD_W:0]         res;
        if (!neg) begin
            q = {1'b0, prod[PROD_W-1:FRAC_W]};
            if (q > (PROD_W-FRAC_W+1)'(32'h7FFF_FFFF)) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, q[COORD_W-1:0]};
            end
        end else begin
            up = {1'b0, prod} + (PROD_W+1)'(24'hFF_FFFF);
            q  = up[PROD_W:FRAC_W];
            if (q > (PROD_W-FRAC_W+1)'(33'h0_8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'h0 - q[COORD_W-1:0]};
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/depth_pixel_backprojection.sv
// An accepted input word passes through the four-step datapath sequence (offset subtract,
//   two multiplies, round/saturate) and its result word then appears on m_tvalid; the next
//   word is taken only once that result has been loaded into the output register.
// A finished result waits in the output register while the next word is taken.
// Reset (aresetn low, synchronous): controller idle, output empty, row and column
//   counters zero, configuration registers at their documented defaults.
`default_nettype none
module depth_pixel_backprojection #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: depth_mm[15:0], mask_label[31:16]
    input  wire logic [dpb_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: frame_start[0]
    input  wire logic                           s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: point_x_q4[31:0], point_y_q4[63:32], point_z_mm[79:64]
    output logic      [dpb_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: point_valid[0], coord_saturated[1]
    output logic      [dpb_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dpb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dpb_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dpb_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import dpb_pkg::*;

    dpb_cfg_t    cfg;
    dpb_cmd_t    cmd;
    dpb_status_t status;
    dpb_state_t  state;

    dpb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    dpb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status)
    );

    // one word in flight: an accept closes the input side next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // skipped pixels carry all-zero coordinates and no saturation flag
    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("skipped pixel with nonzero payload");

    // the output register is only loaded from the final sequencing step
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> ($past(state) == ST_FIN))
        else $error("result appeared outside the final step");

endmodule
`default_nettype wire

// File: rtl/core/dpb_regs.sv
// APB configuration register file for the back-projection block.
`default_nettype none
module dpb_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dpb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dpb_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dpb_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output dpb_pkg::dpb_cfg_t                   cfg
);
    import dpb_pkg::*;

    dpb_cfg_t               cfg_reg;
    dpb_cfg_t               cfg_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_IMAGE_WIDTH:  cfg_next.image_width     = pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height    = pwdata[SIZE_W-1:0];
                REG_CENTER_X:     cfg_next.center_x_q4     = pwdata[CTR_W-1:0];
                REG_CENTER_Y:     cfg_next.center_y_q4     = pwdata[CTR_W-1:0];
                REG_INV_FOCAL_X:  cfg_next.inv_focal_x_q24 = pwdata[INV_W-1:0];
                REG_INV_FOCAL_Y:  cfg_next.inv_focal_y_q24 = pwdata[INV_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width     <= RST_IMAGE_WIDTH;
            cfg_reg.image_height    <= RST_IMAGE_HEIGHT;
            cfg_reg.center_x_q4     <= RST_CENTER_X;
            cfg_reg.center_y_q4     <= RST_CENTER_Y;
            cfg_reg.inv_focal_x_q24 <= RST_INV_FOCAL;
            cfg_reg.inv_focal_y_q24 <= RST_INV_FOCAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_CENTER_X:     prdata = APB_DATA_W'(cfg_reg.center_x_q4);
            REG_CENTER_Y:     prdata = APB_DATA_W'(cfg_reg.center_y_q4);
            REG_INV_FOCAL_X:  prdata = APB_DATA_W'(cfg_reg.inv_focal_x_q24);
            REG_INV_FOCAL_Y:  prdata = APB_DATA_W'(cfg_reg.inv_focal_y_q24);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/dpb_ctrl.sv
// Sequencing state machine: accept, subtract, two multiplies, round and emit.
`default_nettype none
module dpb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  dpb_pkg::dpb_status_t  status,
    output dpb_pkg::dpb_cmd_t     cmd,
    output dpb_pkg::dpb_state_t   state
);
    import dpb_pkg::*;

    dpb_state_t state_reg;
    dpb_state_t state_next;

    assign state = state_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MAG;
            ST_MAG:  state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MAG:  cmd.do_mag  = 1'b1;
            ST_MUL1: cmd.do_mul1 = 1'b1;
            ST_MUL2: cmd.do_mul2 = 1'b1;
            ST_FIN:  cmd.do_out  = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/dpb_datapath.sv
// Position counters, back-projection arithmetic and the output word register.
`default_nettype none
module dpb_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  dpb_pkg::dpb_cmd_t                  cmd,
    input  dpb_pkg::dpb_cfg_t                  cfg,
    input  wire logic [dpb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output logic      [dpb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [dpb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output dpb_pkg::dpb_status_t               status
);
    import dpb_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // position state
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // latched word
    logic [DEPTH_W-1:0] depth_reg;
    logic               valid_reg;
    logic               last_reg;
    logic [COL_W-1:0]   u_reg;
    logic [ROW_W-1:0]   v_reg;

    // arithmetic stages
    logic [MAG_W-1:0]   magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [MZ_W-1:0]    mzx_reg, mzy_reg;
    logic [PROD_W-1:0]  prodx_reg, prody_reg;

    // output word
    logic [COORD_W-1:0] xout_reg, yout_reg;
    logic [DEPTH_W-1:0] zout_reg;
    logic               pvalid_reg, sat_reg, tlast_reg, mvalid_reg;

    logic [DEPTH_W-1:0] depth_in;
    logic [LABEL_W-1:0] label_in;
    logic [COL_W-1:0]   u_in, wm1;
    logic [ROW_W-1:0]   v_in, hm1;
    logic               last_col, last_row;
    logic [CTR_W:0]     px16, py16, cxe, cye, dx, dy;
    logic               negx, negy;
    logic [COORD_W:0]   rx, ry;

    assign depth_in = s_tdata[DEPTH_W-1:0];
    assign label_in = s_tdata[S_TDATA_W-1:DEPTH_W];

    // effective size minus one: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (cfg.image_width == '0) begin
            wm1 = '0;
        end else if (cfg.image_width > SIZE_W'(MAX_WIDTH)) begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = COL_W'(cfg.image_width - SIZE_W'(1));
        end
        if (cfg.image_height == '0) begin
            hm1 = '0;
        end else if (cfg.image_height > SIZE_W'(MAX_HEIGHT)) begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            hm1 = ROW_W'(cfg.image_height - SIZE_W'(1));
        end
    end

    assign u_in     = s_tuser ? '0 : col_reg;
    assign v_in     = s_tuser ? '0 : row_reg;
    assign last_col = u_in >= wm1;
    assign last_row = v_in >= hm1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load_in) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : v_in + ROW_W'(1);
            end else begin
                col_next = u_in + COL_W'(1);
                row_next = v_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            depth_reg <= depth_in;
            valid_reg <= (label_in != '0) && (depth_in != '0);
            last_reg  <= last_col && last_row;
            u_reg     <= u_in;
            v_reg     <= v_in;
        end
    end

    // pixel position in Q4 against the principal point
    assign px16 = (CTR_W+1)'({u_reg, 4'b0000});
    assign py16 = (CTR_W+1)'({v_reg, 4'b0000});
    assign cxe  = {1'b0, cfg.center_x_q4};
    assign cye  = {1'b0, cfg.center_y_q4};
    assign negx = px16 < cxe;
    assign negy = py16 < cye;
    assign dx   = negx ? cxe - px16 : px16 - cxe;
    assign dy   = negy ? cye - py16 : py16 - cye;

    always_ff @(posedge aclk) begin
        if (cmd.do_mag) begin
            magx_reg <= dx[MAG_W-1:0];
            magy_reg <= dy[MAG_W-1:0];
            negx_reg <= negx;
            negy_reg <= negy;
        end
        if (cmd.do_mul1) begin
            mzx_reg <= magx_reg * depth_reg;
            mzy_reg <= magy_reg * depth_reg;
        end
        if (cmd.do_mul2) begin
            prodx_reg <= mzx_reg * cfg.inv_focal_x_q24;
            prody_reg <= mzy_reg * cfg.inv_focal_y_q24;
        end
    end

    assign rx = round_sat(prodx_reg, negx_reg);
    assign ry = round_sat(prody_reg, negy_reg);

    always_ff @(posedge aclk) begin
        if (cmd.do_out) begin
            xout_reg   <= valid_reg ? rx[COORD_W-1:0] : '0;
            yout_reg   <= valid_reg ? ry[COORD_W-1:0] : '0;
            zout_reg   <= valid_reg ? depth_reg : '0;
            pvalid_reg <= valid_reg;
            sat_reg    <= valid_reg && (rx[COORD_W] || ry[COORD_W]);
            tlast_reg  <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.do_out) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {zout_reg, yout_reg, xout_reg};
    assign m_tuser  = {sat_reg, pvalid_reg};
    assign m_tlast  = tlast_reg;

endmodule
`default_nettype wire

// File: verif/depth_pixel_backprojection_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for depth_pixel_backprojection with a built-in pinhole predictor.
module depth_pixel_backprojection_test;
    import dpb_pkg::*;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;

    // addresses past the last register; writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] x_q4;
        logic [COORD_W-1:0] y_q4;
        logic [DEPTH_W-1:0] z_mm;
        logic               valid;
        logic               last;
        logic               clamped;
    } point_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dpb_cfg_t    cfg_shadow;
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    point_t      pending_points[$];

    int mismatches       = 0;
    int points_seen      = 0;
    int points_projected = 0;
    int points_clamped   = 0;
    int frames_closed    = 0;
    int settings_used    = 0;
    bit idle_on          = 1'b1;
    int hold_len         = 0;

    depth_pixel_backprojection #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : watchdog
        #10_000_000;
        $display("depth_pixel_backprojection_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [12:0] clamp_dim(input logic [SIZE_W-1:0] raw, input int limit);
        if (raw == '0) return 13'd1;
        if (raw > limit) return 13'(limit);
        return raw;
    endfunction

    // (pos*16 - center) * z * inv in Q28, floored to Q4, clamped to int32; {clamped, value}
    function automatic logic [COORD_W:0] back_project(input logic [11:0] pos,
                                                      input logic [CTR_W-1:0] center,
                                                      input logic [DEPTH_W-1:0] z,
                                                      input logic [INV_W-1:0] inv);
        logic [15:0] pix;
        logic        neg;
        logic [15:0] mag;
        logic [63:0] prod;
        logic [63:0] q;
        pix  = {pos, 4'b0000};
        neg  = pix < center;
        mag  = neg ? center - pix : pix - center;
        prod = 64'(mag) * 64'(z) * 64'(inv);
        if (!neg) begin
            q = prod >> FRAC_W;
            if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, q[31:0]};
        end
        q = (prod + 64'hFF_FFFF) >> FRAC_W;
        if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
        return {1'b0, 32'd0 - q[31:0]};
    endfunction

    function automatic point_t project_pixel(input logic [DEPTH_W-1:0] depth,
                                             input logic [LABEL_W-1:0] label,
                                             input logic start);
        point_t           pt;
        logic [12:0]      w;
        logic [12:0]      h;
        logic [11:0]      u;
        logic [11:0]      v;
        logic             end_col;
        logic             end_row;
        logic [COORD_W:0] px;
        logic [COORD_W:0] py;
        w       = clamp_dim(cfg_shadow.image_width, MAX_W);
        h       = clamp_dim(cfg_shadow.image_height, MAX_H);
        u       = start ? 12'd0 : col_pos;
        v       = start ? 12'd0 : row_pos;
        end_col = 13'(u) >= w - 13'd1;
        end_row = 13'(v) >= h - 13'd1;
        pt      = '0;
        if (label != '0 && depth != '0) begin
            px         = back_project(u, cfg_shadow.center_x_q4, depth, cfg_shadow.inv_focal_x_q24);
            py         = back_project(v, cfg_shadow.center_y_q4, depth, cfg_shadow.inv_focal_y_q24);
            pt.x_q4    = px[COORD_W-1:0];
            pt.y_q4    = py[COORD_W-1:0];
            pt.z_mm    = depth;
            pt.valid   = 1'b1;
            pt.clamped = px[COORD_W] | py[COORD_W];
        end
        pt.last = end_col & end_row;
        if (end_col) begin
            col_pos = 12'd0;
            row_pos = end_row ? 12'd0 : v + 12'd1;
        end else begin
            col_pos = u + 12'd1;
            row_pos = v;
        end
        return pt;
    endfunction

    // ---------------------------------------------------------------- result side

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_points
        point_t got;
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x_q4    = m_tdata[31:0];
            got.y_q4    = m_tdata[63:32];
            got.z_mm    = m_tdata[79:64];
            got.valid   = m_tuser[0];
            got.clamped = m_tuser[1];
            got.last    = m_tlast;
            points_seen++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point word x=%0d y=%0d z=%0d", $realtime,
                             $signed(got.x_q4), $signed(got.y_q4), got.z_mm);
            end else begin
                want = pending_points.pop_front();
                if (want.valid) points_projected++;
                if (want.clamped) points_clamped++;
                if (want.last) frames_closed++;
                if (got.x_q4 !== want.x_q4 || got.y_q4 !== want.y_q4 ||
                    got.z_mm !== want.z_mm || got.valid !== want.valid ||
                    got.last !== want.last || got.clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: point %0d mismatch", $realtime, points_seen);
                        $display("  expected x=%0d y=%0d z=%0d valid=%b last=%b sat=%b",
                                 $signed(want.x_q4), $signed(want.y_q4), want.z_mm,
                                 want.valid, want.last, want.clamped);
                        $display("  actual   x=%0d y=%0d z=%0d valid=%b last=%b sat=%b",
                                 $signed(got.x_q4), $signed(got.y_q4), got.z_mm,
                                 got.valid, got.last, got.clamped);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_shadow.image_width     = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: cfg_shadow.image_height    = value[SIZE_W-1:0];
            REG_CENTER_X:     cfg_shadow.center_x_q4     = value[CTR_W-1:0];
            REG_CENTER_Y:     cfg_shadow.center_y_q4     = value[CTR_W-1:0];
            REG_INV_FOCAL_X:  cfg_shadow.inv_focal_x_q24 = value[INV_W-1:0];
            REG_INV_FOCAL_Y:  cfg_shadow.inv_focal_y_q24 = value[INV_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setup(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] ifx, input logic [31:0] ify);
        program_reg(REG_IMAGE_WIDTH, w);
        program_reg(REG_IMAGE_HEIGHT, h);
        program_reg(REG_CENTER_X, cx);
        program_reg(REG_CENTER_Y, cy);
        program_reg(REG_INV_FOCAL_X, ifx);
        program_reg(REG_INV_FOCAL_Y, ify);
        settings_used++;
    endtask

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth,
                              input logic [LABEL_W-1:0] label, input logic start);
        int     gap;
        point_t next_pt;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {label, depth};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        next_pt        = project_pixel(depth, label, start);
        pending_points = {pending_points, next_pt};
    endtask

    task automatic send_random_pixel(input logic start);
        logic [DEPTH_W-1:0] depth;
        logic [LABEL_W-1:0] label;
        case ($urandom_range(0, 7))
            0:       depth = '0;
            1:       depth = 16'($urandom_range(1, 64));
            default: depth = 16'($urandom);
        endcase
        label = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        send_pixel(depth, label, start);
    endtask

    // mostly background, with a labelled pixel at each multiple of eight and the position before it
    task automatic send_edge_pixel(input int k, input logic start);
        bit hot;
        hot = (k[2:0] == 3'd0) || (k[2:0] == 3'd7);
        send_pixel(16'($urandom), hot ? 16'($urandom_range(1, 65535)) : 16'd0, start);
    endtask

    // stop offering words and let the block empty out before touching registers
    task automatic wait_points_out();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_frames(input int n_items);
        int sent;
        int frame_px;
        int k;
        sent = 0;
        while (sent < n_items) begin
            frame_px = clamp_dim(cfg_shadow.image_width, MAX_W) *
                       clamp_dim(cfg_shadow.image_height, MAX_H);
            if (frame_px > 48) frame_px = $urandom_range(8, 48);
            for (k = 0; k < frame_px && sent < n_items; k++) begin
                // mostly a clean frame start; now and then none, or a stray one mid-frame
                send_random_pixel(k == 0 ? ($urandom_range(0, 9) != 0)
                                         : ($urandom_range(0, 39) == 0));
                sent++;
            end
        end
    endtask

    function automatic logic [31:0] pick_size();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v[SIZE_W-1:0] = '0;
            1:       v[SIZE_W-1:0] = 13'h1FFF;
            2:       v[SIZE_W-1:0] = 13'(MAX_W);
            3:       v[SIZE_W-1:0] = 13'd1;
            default: v[SIZE_W-1:0] = 13'($urandom_range(2, 12));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_center();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0:       v[CTR_W-1:0] = '0;
            1:       v[CTR_W-1:0] = 16'hFFFF;
            2:       v[CTR_W-1:0] = 16'($urandom);
            default: v[CTR_W-1:0] = 16'($urandom_range(0, 192));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_inv();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 6))
            0:       v[INV_W-1:0] = '0;
            1:       v[INV_W-1:0] = 25'h100_0000;
            2:       v[INV_W-1:0] = 25'h1FF_FFFF;
            3:       v[INV_W-1:0] = 25'($urandom);
            default: v[INV_W-1:0] = 25'($urandom_range(20000, 40000));
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'h1234, 1'b0);
        send_pixel(16'h0800, 16'h0000, 1'b0);
        send_pixel(16'h0001, 16'h0001, 1'b0);
        send_pixel(16'h8000, 16'h0001, 1'b0);
        send_pixel(16'h5555, 16'hAAAA, 1'b0);
        send_pixel(16'hAAAA, 16'h5555, 1'b0);
        wait_points_out();
    endtask

    task automatic test_register_extremes();
        // far principal point with the largest reciprocal: the deepest pixel clamps low in both coordinates
        apply_setup(1, 1, 32'hFFFF, 32'hFFFF, 32'h1FF_FFFF, 32'h1FF_FFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0001, 16'h8000, 1'b0);
        wait_points_out();
        // zero sizes act as one pixel
        apply_setup(0, 0, 0, 0, 0, 0);
        send_pixel(16'hFFFF, 16'h0001, 1'b0);
        send_pixel(16'h1234, 16'hFFFF, 1'b1);
        wait_points_out();
        apply_setup(32'h1FFF, 32'h1FFF, 16, 16, 32'h100_0000, 32'h100_0000);
        send_pixel(16'hFFFF, 16'h00FF, 1'b1);
        send_pixel(16'h0010, 16'hFF00, 1'b0);
        wait_points_out();
    endtask

    task automatic test_size_change_midframe();
        int k;
        apply_setup(16, 8, 120, 64, 27962, 27962);
        send_random_pixel(1'b1);
        for (k = 0; k < 10; k++) send_random_pixel(1'b0);
        wait_points_out();
        // column now sits past the new width: that pixel ends its row
        program_reg(REG_IMAGE_WIDTH, 4);
        for (k = 0; k < 3; k++) send_random_pixel(1'b0);
        wait_points_out();
        program_reg(REG_IMAGE_HEIGHT, 1);
        for (k = 0; k < 3; k++) send_random_pixel(1'b0);
        wait_points_out();
    endtask

    task automatic test_unknown_registers();
        program_reg(REG_SPARE_A, $urandom);
        program_reg(REG_SPARE_B, $urandom);
        send_pixel(16'h0400, 16'h0007, 1'b1);
        send_pixel(16'hFFFF, 16'h0001, 1'b0);
        wait_points_out();
    endtask

    task automatic test_sensor_edges();
        int k;
        idle_on = 1'b0;
        // several whole rows: column counter wraps at the width, frame closes and restarts
        apply_setup(48, 3, 0, 0, 32'h1FF_FFFF, 32'h1FF_FFFF);
        for (k = 0; k <= 48 * 3 + 4; k++) send_edge_pixel(k, k == 0);
        wait_points_out();
        // one-pixel rows: the row counter does the same
        apply_setup(1, 40, 0, 0, 32'h100_0000, 32'h1FF_FFFF);
        for (k = 0; k <= 40 + 4; k++) send_edge_pixel(k, k == 0);
        wait_points_out();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        int k;
        apply_setup(7, 5, 50, 40, 30000, 26000);
        idle_on  = 1'b0;
        hold_len = 300;
        for (k = 0; k < 30; k++) send_random_pixel(k == 0);
        wait_points_out();
        idle_on = 1'b1;
        for (k = 0; k < 15; k++) send_random_pixel(1'b0);
        wait_points_out();
        for (k = 0; k < 15; k++) send_random_pixel(1'b0);
        wait_points_out();
    endtask

    task automatic test_register_sweep();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            idle_on = (phase % 4) != 3;
            apply_setup(pick_size(), pick_size(), pick_center(), pick_center(),
                        pick_inv(), pick_inv());
            run_frames(50);
            wait_points_out();
        end
        idle_on = 1'b1;
    endtask

    initial begin : test_sequence
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_shadow.image_width     = RST_IMAGE_WIDTH;
        cfg_shadow.image_height    = RST_IMAGE_HEIGHT;
        cfg_shadow.center_x_q4     = RST_CENTER_X;
        cfg_shadow.center_y_q4     = RST_CENTER_Y;
        cfg_shadow.inv_focal_x_q24 = RST_INV_FOCAL;
        cfg_shadow.inv_focal_y_q24 = RST_INV_FOCAL;
        col_pos = '0;
        row_pos = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_size_change_midframe();
        test_unknown_registers();
        test_sensor_edges();
        test_backpressure();
        test_register_sweep();

        wait_points_out();
        repeat (20) @(posedge aclk);
        mismatches += pending_points.size();
        $display("checked %0d point words: %0d projected, %0d clamped, %0d frame ends",
                 points_seen, points_projected, points_clamped, frames_closed);
        $display("over %0d register setups with random stalls and long hold-offs",
                 settings_used);
        if (mismatches == 0) begin
            $display("depth_pixel_backprojection_test: clean");
        end else begin
            $display("depth_pixel_backprojection_test: errors");
        end
        $finish;
    end

endmodule
